### rtl/mbhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive base halt supervisor package
// Register map, event codes, reset values and helpers shared by the block.
// ----------------------------------------------------------------------------
package mbhs_pkg;

   localparam int DEF_MAX_WHEELS = 8;
   localparam int DEF_TIME_BITS  = 32;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int THR_BITS      = 15;
   localparam int TIMEOUT_BITS  = 32;
   localparam int WCOUNT_BITS   = 4;
   localparam int SAMPLE_BITS   = 16;
   localparam int INDEX_BITS    = 3;
   localparam int CMD_BITS      = 2;
   localparam int REQ_DATA_BITS = 120;
   localparam int RSP_DATA_BITS = 8;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_STOP_THRESHOLD  = 3'd0,
      CSR_STUCK_THRESHOLD = 3'd1,
      CSR_STOP_TIMEOUT    = 3'd2,
      CSR_STUCK_TIMEOUT   = 3'd3,
      CSR_RECOVER_TIMEOUT = 3'd4,
      CSR_DIAG_HOLDOFF    = 3'd5,
      CSR_WHEEL_COUNT     = 3'd6
   } csr_addr_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK  = 2'd0,
      CMD_TWIST = 2'd1,
      CMD_WHEEL = 2'd2,
      CMD_DIAG  = 2'd3
   } cmd_type;

   localparam logic [THR_BITS-1:0]     RST_STOP_THRESHOLD  = 15'd410;
   localparam logic [THR_BITS-1:0]     RST_STUCK_THRESHOLD = 15'd4096;
   localparam logic [TIMEOUT_BITS-1:0] RST_STOP_TIMEOUT    = 32'd1000;
   localparam logic [TIMEOUT_BITS-1:0] RST_STUCK_TIMEOUT   = 32'd1000;
   localparam logic [TIMEOUT_BITS-1:0] RST_RECOVER_TIMEOUT = 32'd1000;
   localparam logic [TIMEOUT_BITS-1:0] RST_DIAG_HOLDOFF    = 32'd2000;
   localparam logic [WCOUNT_BITS-1:0]  RST_WHEEL_COUNT     = 4'd4;

   // Magnitude of a signed Q4.12 sample; the most negative value maps to 0x8000.
   function automatic logic [SAMPLE_BITS-1:0] mag16(input logic [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] neg;
      neg = SAMPLE_BITS'(~v + 1'b1);
      return v[SAMPLE_BITS-1] ? neg : v;
   endfunction

   // A timeout of zero behaves as one tick.
   function automatic logic [TIMEOUT_BITS-1:0] eff_timeout(input logic [TIMEOUT_BITS-1:0] t);
      return (t == '0) ? TIMEOUT_BITS'(1) : t;
   endfunction

endpackage

`default_nettype wire

### rtl/mobile_base_halt_supervisor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive base halt supervisor
// A word taken on req goes through the input and result registers to rsp.
// Throughput: one word per cycle; the input register and the result register
// each stall only when the stage after them holds a word that is not taken.
// The state update is one pass of compares and adds between the two.
// Reset (synchronous, active high) restores register and state defaults.
// ----------------------------------------------------------------------------
module mobile_base_halt_supervisor_top #(
   parameter int MAX_WHEELS = mbhs_pkg::DEF_MAX_WHEELS,
   parameter int TIME_BITS  = mbhs_pkg::DEF_TIME_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input words.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // wheel_index[2:0], wheel_error[18:3], lin_x[34:19], lin_y[50:35],
   // lin_z[66:51], ang_x[82:67], ang_y[98:83], ang_z[114:99], zero above
   input  wire logic [mbhs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // cmd[1:0]
   input  wire logic [mbhs_pkg::CMD_BITS-1:0]       req_tuser,
   // wheel_set_last
   input  wire logic                                req_tlast,
   // Result words.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // halt_pulse[0], recover_pulse[1], is_stopped[2], is_stuck[3],
   // stuck_allowed[4], zero above
   output logic [mbhs_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // Register writes.
   input  wire logic                                csr_we,
   input  wire logic [mbhs_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [mbhs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CMP_BITS = (TIME_BITS > mbhs_pkg::TIMEOUT_BITS) ?
                             TIME_BITS : mbhs_pkg::TIMEOUT_BITS;
   localparam int SB       = mbhs_pkg::SAMPLE_BITS;
   localparam int WI_BITS  = 5;

   // Configuration registers.
   logic [mbhs_pkg::THR_BITS-1:0]     stop_thr_ff, stuck_thr_ff;
   logic [mbhs_pkg::TIMEOUT_BITS-1:0] stop_to_ff, stuck_to_ff, rec_to_ff, diag_hold_ff;
   logic [mbhs_pkg::WCOUNT_BITS-1:0]  wheel_count_ff;

   // Input register.
   logic                              s1_valid_ff;
   logic [mbhs_pkg::CMD_BITS-1:0]     s1_cmd_ff;
   logic [mbhs_pkg::INDEX_BITS-1:0]   s1_idx_ff;
   logic [SB-1:0]                     s1_err_ff;
   logic                              s1_last_ff;
   logic [SB-1:0]                     s1_twist_ff [6];

   // Supervisor state.
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] good_time_ff [MAX_WHEELS];
   logic [TIME_BITS-1:0] wheel_eff [MAX_WHEELS];
   logic                 started_ff, started_in;
   logic                 stop_on_ff, stop_on_in;
   logic [TIME_BITS-1:0] stop_dl_ff, stop_dl_in;
   logic                 rec_on_ff, rec_on_in;
   logic [TIME_BITS-1:0] rec_dl_ff, rec_dl_in;
   logic                 rearm_on_ff, rearm_on_in;
   logic [TIME_BITS-1:0] rearm_dl_ff, rearm_dl_in;
   logic                 stopped_ff, stopped_in;
   logic                 stuck_ff, stuck_in;
   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] last_diag_ff, last_diag_in;

   // Result register.
   logic                 rsp_valid_ff;
   logic [4:0]           rsp_bits_ff, rsp_bits_in;

   // Per-item working signals.
   logic                 s1_adv;
   logic                 fire;
   logic [TIME_BITS-1:0] cur_time;
   logic [TIME_BITS-1:0] dl_stop, dl_stuck, dl_rec;
   logic                 moving;
   logic                 refresh;
   logic                 exceeded;
   logic                 diag_ok;
   logic                 halt, rec;

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign fire       = s1_valid_ff && s1_adv;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_bits_ff};

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_thr_ff    <= mbhs_pkg::RST_STOP_THRESHOLD;
         stuck_thr_ff   <= mbhs_pkg::RST_STUCK_THRESHOLD;
         stop_to_ff     <= mbhs_pkg::RST_STOP_TIMEOUT;
         stuck_to_ff    <= mbhs_pkg::RST_STUCK_TIMEOUT;
         rec_to_ff      <= mbhs_pkg::RST_RECOVER_TIMEOUT;
         diag_hold_ff   <= mbhs_pkg::RST_DIAG_HOLDOFF;
         wheel_count_ff <= mbhs_pkg::RST_WHEEL_COUNT;
      end else if (csr_we) begin
         unique case (mbhs_pkg::csr_addr_type'(csr_addr))
            mbhs_pkg::CSR_STOP_THRESHOLD:  stop_thr_ff    <= csr_wdata[mbhs_pkg::THR_BITS-1:0];
            mbhs_pkg::CSR_STUCK_THRESHOLD: stuck_thr_ff   <= csr_wdata[mbhs_pkg::THR_BITS-1:0];
            mbhs_pkg::CSR_STOP_TIMEOUT:    stop_to_ff     <= csr_wdata;
            mbhs_pkg::CSR_STUCK_TIMEOUT:   stuck_to_ff    <= csr_wdata;
            mbhs_pkg::CSR_RECOVER_TIMEOUT: rec_to_ff      <= csr_wdata;
            mbhs_pkg::CSR_DIAG_HOLDOFF:    diag_hold_ff   <= csr_wdata;
            mbhs_pkg::CSR_WHEEL_COUNT:     wheel_count_ff <= csr_wdata[mbhs_pkg::WCOUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_cmd_ff      <= req_tuser;
         s1_last_ff     <= req_tlast;
         s1_idx_ff      <= req_tdata[2:0];
         s1_err_ff      <= req_tdata[18:3];
         s1_twist_ff[0] <= req_tdata[34:19];
         s1_twist_ff[1] <= req_tdata[50:35];
         s1_twist_ff[2] <= req_tdata[66:51];
         s1_twist_ff[3] <= req_tdata[82:67];
         s1_twist_ff[4] <= req_tdata[98:83];
         s1_twist_ff[5] <= req_tdata[114:99];
      end
   end

   // ------------------------------------------------------- update logic
   // A tick advances time first; every deadline set by this word counts from it.
   assign cur_time = (mbhs_pkg::cmd_type'(s1_cmd_ff) == mbhs_pkg::CMD_TICK) ?
                     TIME_BITS'(now_ff + 1'b1) : now_ff;

   assign dl_stop  = TIME_BITS'(CMP_BITS'(cur_time) +
                                CMP_BITS'(mbhs_pkg::eff_timeout(stop_to_ff)));
   assign dl_stuck = TIME_BITS'(CMP_BITS'(cur_time) +
                                CMP_BITS'(mbhs_pkg::eff_timeout(stuck_to_ff)));
   assign dl_rec   = TIME_BITS'(CMP_BITS'(cur_time) +
                                CMP_BITS'(mbhs_pkg::eff_timeout(rec_to_ff)));

   always_comb begin
      moving = 1'b0;
      for (int k = 0; k < 6; k++) begin
         if (mbhs_pkg::mag16(s1_twist_ff[k]) >= SB'(stop_thr_ff)) begin
            moving = 1'b1;
         end
      end
   end

   assign refresh = mbhs_pkg::mag16(s1_err_ff) < SB'(stuck_thr_ff);

   // Effective last-good time of each wheel after this sample, and the stuck check.
   always_comb begin
      exceeded = 1'b0;
      for (int i = 0; i < MAX_WHEELS; i++) begin
         if (!started_ff ||
             (refresh && ({2'b00, s1_idx_ff} == WI_BITS'(i)) &&
              (WI_BITS'(i) < {1'b0, wheel_count_ff}))) begin
            wheel_eff[i] = now_ff;
         end else begin
            wheel_eff[i] = good_time_ff[i];
         end
         if ((WI_BITS'(i) < {1'b0, wheel_count_ff}) &&
             (CMP_BITS'(TIME_BITS'(now_ff - wheel_eff[i])) >= CMP_BITS'(stuck_to_ff))) begin
            exceeded = 1'b1;
         end
      end
   end

   assign diag_ok = CMP_BITS'(TIME_BITS'(now_ff - last_diag_ff)) >= CMP_BITS'(diag_hold_ff);

   always_comb begin
      now_in       = now_ff;
      started_in   = started_ff;
      stop_on_in   = stop_on_ff;
      stop_dl_in   = stop_dl_ff;
      rec_on_in    = rec_on_ff;
      rec_dl_in    = rec_dl_ff;
      rearm_on_in  = rearm_on_ff;
      rearm_dl_in  = rearm_dl_ff;
      stopped_in   = stopped_ff;
      stuck_in     = stuck_ff;
      armed_in     = armed_ff;
      last_diag_in = last_diag_ff;
      halt         = 1'b0;
      rec          = 1'b0;

      unique case (mbhs_pkg::cmd_type'(s1_cmd_ff))
         mbhs_pkg::CMD_TICK: begin
            now_in = cur_time;
            if (stop_on_ff && cur_time == stop_dl_ff) begin
               stop_on_in = 1'b0;
               stopped_in = 1'b1;
               halt       = 1'b1;
            end
            if (rec_on_ff && cur_time == rec_dl_ff) begin
               rec_on_in   = 1'b0;
               rec         = 1'b1;
               stopped_in  = 1'b0;
               stuck_in    = 1'b0;
               stop_on_in  = 1'b1;
               stop_dl_in  = dl_stop;
               rearm_on_in = 1'b1;
               rearm_dl_in = dl_stuck;
            end
            // A holdoff that wraps onto the current time expires at once.
            if (rearm_on_in && cur_time == rearm_dl_in) begin
               rearm_on_in = 1'b0;
               armed_in    = 1'b1;
            end
         end
         mbhs_pkg::CMD_TWIST: begin
            if (moving) begin
               stop_on_in = 1'b0;
               if (!stuck_ff) begin
                  if (stopped_ff) begin
                     rec        = 1'b1;
                     stopped_in = 1'b0;
                  end
                  stop_on_in = 1'b1;
                  stop_dl_in = dl_stop;
               end
            end
         end
         mbhs_pkg::CMD_WHEEL: begin
            started_in = 1'b1;
            if (s1_last_ff && exceeded && !stuck_ff && !stopped_ff && armed_ff) begin
               stuck_in  = 1'b1;
               armed_in  = 1'b0;
               halt      = 1'b1;
               rec_on_in = 1'b1;
               rec_dl_in = dl_rec;
            end
         end
         mbhs_pkg::CMD_DIAG: begin
            if (!stuck_ff && !stopped_ff && diag_ok) begin
               rec          = 1'b1;
               last_diag_in = now_ff;
            end
         end
         default: ;
      endcase

      rsp_bits_in = {armed_in, stuck_in, stopped_in, rec, halt};
   end

   // ---------------------------------------------------------- state regs
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         started_ff   <= 1'b0;
         stop_on_ff   <= 1'b0;
         stop_dl_ff   <= '0;
         rec_on_ff    <= 1'b0;
         rec_dl_ff    <= '0;
         rearm_on_ff  <= 1'b0;
         rearm_dl_ff  <= '0;
         stopped_ff   <= 1'b0;
         stuck_ff     <= 1'b0;
         armed_ff     <= 1'b1;
         last_diag_ff <= '0;
      end else if (fire) begin
         now_ff       <= now_in;
         started_ff   <= started_in;
         stop_on_ff   <= stop_on_in;
         stop_dl_ff   <= stop_dl_in;
         rec_on_ff    <= rec_on_in;
         rec_dl_ff    <= rec_dl_in;
         rearm_on_ff  <= rearm_on_in;
         rearm_dl_ff  <= rearm_dl_in;
         stopped_ff   <= stopped_in;
         stuck_ff     <= stuck_in;
         armed_ff     <= armed_in;
         last_diag_ff <= last_diag_in;
      end
   end

   // The first wheel word fills every entry, so no entry is read unwritten.
   always_ff @(posedge clock) begin
      if (fire && mbhs_pkg::cmd_type'(s1_cmd_ff) == mbhs_pkg::CMD_WHEEL) begin
         for (int i = 0; i < MAX_WHEELS; i++) begin
            good_time_ff[i] <= wheel_eff[i];
         end
      end
   end

   // ------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_bits_ff <= rsp_bits_in;
      end
   end

endmodule

`default_nettype wire

### sim/mbhs_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halt supervisor status checker
// Watches the request, result and register ports of the halt supervisor,
// predicts the status word that each accepted request word must produce and
// compares every result word with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mbhs_status_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // wheel_index[2:0], wheel_error[18:3], lin_x .. ang_z in 16 bit steps from 19
   input  wire logic [mbhs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // cmd[1:0]
   input  wire logic [mbhs_pkg::CMD_BITS-1:0]       req_tuser,
   input  wire logic                                req_tlast,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // halt_pulse[0], recover_pulse[1], is_stopped[2], is_stuck[3], stuck_allowed[4]
   input  wire logic [mbhs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [mbhs_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [mbhs_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                       mismatch_count,
   output int                                       pending_count
);
   import mbhs_pkg::*;

   localparam int WHEELS = DEF_MAX_WHEELS;
   localparam int TW     = DEF_TIME_BITS;

   // Bit order matches the result word, halt_pulse in bit 0.
   typedef struct packed {
      logic armed;
      logic stuck;
      logic stopped;
      logic recover;
      logic halt;
   } base_status_type;

   base_status_type status_due_q [$];
   int              mismatches = 0;
   int              results_seen = 0;

   // Register copies.
   logic [THR_BITS-1:0]     stop_thr, stuck_thr;
   logic [TIMEOUT_BITS-1:0] stop_tmo, stuck_tmo, recover_tmo, diag_hold;
   logic [WCOUNT_BITS-1:0]  wheel_cnt;

   // Supervisor state.
   logic [TW-1:0] now_ticks;
   logic [TW-1:0] good_time [WHEELS];
   logic          wheels_seen;
   logic          stop_on, recover_on, rearm_on;
   logic [TW-1:0] stop_due, recover_due, rearm_due;
   logic          stopped, stuck, armed;
   logic [TW-1:0] last_diag;

   function automatic logic [15:0] magnitude(input logic [15:0] v);
      return v[15] ? 16'(-v) : v;
   endfunction

   function automatic logic [TW-1:0] timer_span(input logic [TIMEOUT_BITS-1:0] t);
      return (t == '0) ? TW'(1) : TW'(t);
   endfunction

   task automatic restore_defaults();
      stop_thr    = RST_STOP_THRESHOLD;
      stuck_thr   = RST_STUCK_THRESHOLD;
      stop_tmo    = RST_STOP_TIMEOUT;
      stuck_tmo   = RST_STUCK_TIMEOUT;
      recover_tmo = RST_RECOVER_TIMEOUT;
      diag_hold   = RST_DIAG_HOLDOFF;
      wheel_cnt   = RST_WHEEL_COUNT;
      now_ticks   = '0;
      for (int i = 0; i < WHEELS; i++) good_time[i] = '0;
      wheels_seen = 1'b0;
      stop_on     = 1'b0;
      recover_on  = 1'b0;
      rearm_on    = 1'b0;
      stop_due    = '0;
      recover_due = '0;
      rearm_due   = '0;
      stopped     = 1'b0;
      stuck       = 1'b0;
      armed       = 1'b1;
      last_diag   = '0;
   endtask

   task automatic step_supervisor(input cmd_type cmd, input logic [2:0] idx,
                                  input logic [15:0] err, input logic set_last,
                                  input logic [5:0][15:0] twist,
                                  output base_status_type st);
      logic halt, rec, moving, over;
      int   nw;
      halt   = 1'b0;
      rec    = 1'b0;
      moving = 1'b0;
      over   = 1'b0;
      nw     = (int'(wheel_cnt) > WHEELS) ? WHEELS : int'(wheel_cnt);
      case (cmd)
         CMD_TICK: begin
            now_ticks = now_ticks + 1'b1;
            if (stop_on && now_ticks == stop_due) begin
               stop_on = 1'b0;
               stopped = 1'b1;
               halt    = 1'b1;
            end
            if (recover_on && now_ticks == recover_due) begin
               recover_on = 1'b0;
               rec        = 1'b1;
               stopped    = 1'b0;
               stuck      = 1'b0;
               stop_on    = 1'b1;
               stop_due   = now_ticks + timer_span(stop_tmo);
               rearm_on   = 1'b1;
               rearm_due  = now_ticks + timer_span(stuck_tmo);
            end
            if (rearm_on && now_ticks == rearm_due) begin
               rearm_on = 1'b0;
               armed    = 1'b1;
            end
         end
         CMD_TWIST: begin
            for (int k = 0; k < 6; k++)
               if (magnitude(twist[k]) >= {1'b0, stop_thr}) moving = 1'b1;
            if (moving) begin
               stop_on = 1'b0;
               if (!stuck) begin
                  if (stopped) begin
                     rec     = 1'b1;
                     stopped = 1'b0;
                  end
                  stop_on  = 1'b1;
                  stop_due = now_ticks + timer_span(stop_tmo);
               end
            end
         end
         CMD_WHEEL: begin
            // The first sample seeds every wheel, so no entry is read unwritten.
            if (!wheels_seen) begin
               for (int i = 0; i < WHEELS; i++) good_time[i] = now_ticks;
               wheels_seen = 1'b1;
            end
            if (int'(idx) < nw && magnitude(err) < {1'b0, stuck_thr})
               good_time[idx] = now_ticks;
            if (set_last) begin
               for (int i = 0; i < nw; i++)
                  if (TW'(now_ticks - good_time[i]) >= stuck_tmo) over = 1'b1;
               if (over && !stuck && !stopped && armed) begin
                  stuck       = 1'b1;
                  armed       = 1'b0;
                  halt        = 1'b1;
                  recover_on  = 1'b1;
                  recover_due = now_ticks + timer_span(recover_tmo);
               end
            end
         end
         default: begin
            if (!stuck && !stopped && TW'(now_ticks - last_diag) >= diag_hold) begin
               rec       = 1'b1;
               last_diag = now_ticks;
            end
         end
      endcase
      st.halt    = halt;
      st.recover = rec;
      st.stopped = stopped;
      st.stuck   = stuck;
      st.armed   = armed;
   endtask

   always @(posedge clock) begin
      base_status_type predicted, seen;
      if (reset) begin
         restore_defaults();
         status_due_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = base_status_type'(rsp_tdata[4:0]);
            results_seen++;
            if (status_due_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result word %0d arrived with no word pending: %b",
                           results_seen, seen);
            end else begin
               predicted = status_due_q.pop_front();
               if (seen.halt !== predicted.halt || seen.recover !== predicted.recover ||
                   seen.stopped !== predicted.stopped || seen.stuck !== predicted.stuck ||
                   seen.armed !== predicted.armed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result word %0d: expected halt=%b recover=%b stopped=%b ",
                               "stuck=%b allowed=%b, got halt=%b recover=%b stopped=%b ",
                               "stuck=%b allowed=%b"}, results_seen,
                              predicted.halt, predicted.recover, predicted.stopped,
                              predicted.stuck, predicted.armed, seen.halt, seen.recover,
                              seen.stopped, seen.stuck, seen.armed);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_supervisor(cmd_type'(req_tuser), req_tdata[2:0], req_tdata[18:3],
                            req_tlast, req_tdata[114:19], predicted);
            status_due_q.push_back(predicted);
         end
         if (csr_we) begin
            case (csr_addr_type'(csr_addr))
               CSR_STOP_THRESHOLD:  stop_thr    = csr_wdata[THR_BITS-1:0];
               CSR_STUCK_THRESHOLD: stuck_thr   = csr_wdata[THR_BITS-1:0];
               CSR_STOP_TIMEOUT:    stop_tmo    = csr_wdata[TIMEOUT_BITS-1:0];
               CSR_STUCK_TIMEOUT:   stuck_tmo   = csr_wdata[TIMEOUT_BITS-1:0];
               CSR_RECOVER_TIMEOUT: recover_tmo = csr_wdata[TIMEOUT_BITS-1:0];
               CSR_DIAG_HOLDOFF:    diag_hold   = csr_wdata[TIMEOUT_BITS-1:0];
               CSR_WHEEL_COUNT:     wheel_cnt   = csr_wdata[WCOUNT_BITS-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= status_due_q.size();
   end

endmodule

### sim/tb_mobile_base_halt_supervisor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halt supervisor testbench
// Drives directed and random tick, twist, wheel and diagnostic words through
// several register settings, with random gaps and back pressure, and takes
// the verdict from the status checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_mobile_base_halt_supervisor_top;
   import mbhs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 1250;
   localparam int PHASES       = 9;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [CMD_BITS-1:0]      req_tuser  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int words_sent  = 0;
   bit idling_on   = 1'b1;

   // Settings currently loaded, kept here to shape the stimulus.
   int          stop_thr  = RST_STOP_THRESHOLD;
   int          stuck_thr = RST_STUCK_THRESHOLD;
   int          wheel_cnt = RST_WHEEL_COUNT;
   logic [31:0] stop_tmo, stuck_tmo, recover_tmo, diag_hold;
   logic [7:0]  wheel_bad = '0;

   mobile_base_halt_supervisor_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   mbhs_status_checker status_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Result side back pressure.
   initial begin
      @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   function automatic logic [15:0] signed_sample(input int mag);
      return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
   endfunction

   // A sample whose magnitude stays below the threshold, or zero if it is zero.
   function automatic logic [15:0] weak_sample(input int thr);
      return (thr == 0) ? 16'h0000 : signed_sample($urandom_range(0, thr - 1));
   endfunction

   // A sample whose magnitude reaches the threshold.
   function automatic logic [15:0] strong_sample(input int thr);
      case ($urandom_range(0, 3))
         0:       return signed_sample(thr);
         1:       return 16'h8000;
         2:       return signed_sample($urandom_range(32767, thr));
         default: return signed_sample(32767);
      endcase
   endfunction

   function automatic logic [5:0][15:0] junk_twist();
      return {$urandom, $urandom, $urandom};
   endfunction

   task automatic send_word(input cmd_type cmd, input logic [2:0] idx, input logic [15:0] err,
                            input logic set_last, input logic [5:0][15:0] twist);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= set_last;
      req_tdata  <= REQ_DATA_BITS'({twist, err, idx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_twist(input bit moving);
      logic [5:0][15:0] twist;
      for (int k = 0; k < 6; k++) twist[k] = weak_sample(stop_thr);
      if (moving) twist[$urandom_range(0, 5)] = strong_sample(stop_thr);
      send_word(CMD_TWIST, 3'($urandom), 16'($urandom), 1'($urandom), twist);
   endtask

   // One well-formed wheel message; bad wheels persist over several messages.
   task automatic send_wheel_set();
      int          nw, count;
      logic [2:0]  idx;
      logic [15:0] err;
      nw    = (wheel_cnt > 8) ? 8 : wheel_cnt;
      count = (nw == 0) ? 1 : nw;
      if ($urandom_range(0, 3) == 0)
         wheel_bad = $urandom_range(0, 1) ? 8'h00 : (8'h01 << $urandom_range(0, 7));
      for (int i = 0; i < count; i++) begin
         idx = 3'(i);
         if (i == count - 1 && $urandom_range(0, 5) == 0) idx = 3'($urandom);
         err = wheel_bad[idx] ? strong_sample(stuck_thr) : weak_sample(stuck_thr);
         send_word(CMD_WHEEL, idx, err, i == count - 1, junk_twist());
      end
   endtask

   task automatic send_tick();
      send_word(CMD_TICK, 3'($urandom), 16'($urandom), 1'($urandom), junk_twist());
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_addr_type addr, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input int phase);
      case (phase)
         0: begin
            stop_thr = 410; stuck_thr = 4096; wheel_cnt = 2;
            stop_tmo = 1; stuck_tmo = 2; recover_tmo = 1; diag_hold = 0;
         end
         1: begin
            // Zero thresholds and timeouts: every twist moves, no wheel is good.
            stop_thr = 0; stuck_thr = 0; wheel_cnt = 1;
            stop_tmo = 0; stuck_tmo = 0; recover_tmo = 0; diag_hold = 0;
         end
         2: begin
            stop_thr = 32767; stuck_thr = 32767; wheel_cnt = 8;
            stop_tmo = '1; stuck_tmo = '1; recover_tmo = '1; diag_hold = '1;
         end
         3: begin
            // No wheel in use, so no stuck halt can happen.
            stop_thr = 300; stuck_thr = 3000; wheel_cnt = 0;
            stop_tmo = 4; stuck_tmo = 3; recover_tmo = 2; diag_hold = 5;
         end
         4: begin
            // Counts above the wheel limit are clamped.
            stop_thr = 1000; stuck_thr = 2000; wheel_cnt = 15;
            stop_tmo = 12; stuck_tmo = 3; recover_tmo = 4; diag_hold = 8;
         end
         default: begin
            stop_thr    = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                   : $urandom_range(200, 6000);
            stuck_thr   = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                   : $urandom_range(200, 6000);
            wheel_cnt   = $urandom_range(1, 8);
            stop_tmo    = $urandom_range(1, 30);
            stuck_tmo   = $urandom_range(1, 30);
            recover_tmo = $urandom_range(1, 30);
            diag_hold   = $urandom_range(0, 40);
         end
      endcase
      wait_for_idle();
      write_reg(CSR_STOP_THRESHOLD, stop_thr);
      write_reg(CSR_STUCK_THRESHOLD, stuck_thr);
      write_reg(CSR_STOP_TIMEOUT, stop_tmo);
      write_reg(CSR_STUCK_TIMEOUT, stuck_tmo);
      write_reg(CSR_RECOVER_TIMEOUT, recover_tmo);
      write_reg(CSR_DIAG_HOLDOFF, diag_hold);
      write_reg(CSR_WHEEL_COUNT, wheel_cnt);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [5:0][15:0] twist;
      int               pick, phase_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: diagnostic holdoff from time zero, threshold edges,
      // the first wheel sample and an index past the wheel count.
      send_word(CMD_DIAG, 3'd0, 16'h0000, 1'b0, '0);
      send_word(CMD_TICK, 3'd7, 16'hFFFF, 1'b1, '1);
      twist = '0;
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      twist[0] = 16'd409;
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      twist[0] = 16'(-410);
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      twist = '0; twist[5] = 16'h8000;
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      twist = '0; twist[4] = 16'h7FFF;
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      send_word(CMD_WHEEL, 3'd0, 16'h0000, 1'b0, '0);
      send_word(CMD_WHEEL, 3'd7, 16'h8000, 1'b1, '0);
      send_word(CMD_WHEEL, 3'd3, 16'd4095, 1'b1, '0);
      send_word(CMD_WHEEL, 3'd2, 16'd4096, 1'b1, '0);

      // Short timers: stop expiry, a stuck halt, stop and recover expiring on
      // the same tick, re-arm, and diagnostic recovery with no holdoff.
      load_settings(0);
      twist = '0; twist[3] = 16'd1000;
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      send_word(CMD_WHEEL, 3'd0, 16'h0000, 1'b0, '0);
      send_word(CMD_WHEEL, 3'd1, 16'd100, 1'b1, '0);
      send_tick();
      send_tick();
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      send_word(CMD_WHEEL, 3'd0, 16'd20000, 1'b0, '0);
      send_word(CMD_WHEEL, 3'd1, 16'(-20000), 1'b1, '0);
      send_tick();
      send_tick();
      send_tick();
      send_word(CMD_DIAG, 3'd0, 16'h0000, 1'b0, '0);
      send_word(CMD_TWIST, 3'd0, 16'h0000, 1'b0, twist);
      send_word(CMD_DIAG, 3'd0, 16'h0000, 1'b0, '0);
      send_word(CMD_WHEEL, 3'd5, 16'h0000, 1'b1, '0);

      for (int phase = 1; phase <= PHASES; phase++) begin
         if (phase > 1) load_settings(phase - 1);
         idling_on = (phase != 4 && phase < PHASES - 1);
         phase_end = words_sent + RANDOM_WORDS / PHASES;
         while (words_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               repeat ($urandom_range(1, 4)) send_tick();
            else if (pick < 55)
               send_twist($urandom_range(0, 1));
            else if (pick < 85)
               send_wheel_set();
            else if (pick < 92)
               send_word(CMD_DIAG, 3'($urandom), 16'($urandom), 1'($urandom), junk_twist());
            else
               send_word(cmd_type'($urandom_range(0, 3)), 3'($urandom), 16'($urandom),
                         1'($urandom), junk_twist());
         end
      end

      wait_for_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
